### design/toy_language_tokenizer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the toy language tokenizer
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOY_LANGUAGE_TOKENIZER_TOP_ASSERT_SVH
`define TOY_LANGUAGE_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define TLT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tokenizer check failed");

`define TLT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

`define TLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`else

`define TLT_ASSERT_ALWAYS(label, clk, rst, expr)
`define TLT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TLT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/tlt_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Types, token kinds, character codes and keyword tables shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

   localparam int OFFSET_BITS   = 16;
   localparam int KEYWORD_CHARS = 6;
   localparam int KW_COUNT      = 8;
   localparam int KW_MAX_LEN    = 6;
   localparam int SINGLE_COUNT  = 12;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   localparam logic [4:0] KIND_IDENT   = 5'd0;
   localparam logic [4:0] KIND_NUMBER  = 5'd1;
   localparam logic [4:0] KIND_KW0     = 5'd2;
   localparam logic [4:0] KIND_EQ      = 5'd10;
   localparam logic [4:0] KIND_NE      = 5'd11;
   localparam logic [4:0] KIND_GE      = 5'd12;
   localparam logic [4:0] KIND_GT      = 5'd13;
   localparam logic [4:0] KIND_LE      = 5'd14;
   localparam logic [4:0] KIND_LT      = 5'd15;
   localparam logic [4:0] KIND_SINGLE0 = 5'd16;
   localparam logic [4:0] KIND_ASSIGN  = 5'd21;
   localparam logic [4:0] KIND_END     = 5'd28;
   localparam logic [4:0] KIND_UNKNOWN = 5'd29;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_LT   = 8'h3C;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_GT   = 8'h3E;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"v", "o", "i", "d", 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"r", "e", "t", "u", "r", "n"}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6
   };

   localparam logic [7:0] SINGLE_CHARS [SINGLE_COUNT] = '{
      "{", "}", "(", ")", ";", "=", ":", ",", "+", "-", "*", "/"
   };

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  odd;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_out_type;

   function automatic logic [15:0] start_field(input logic [OFFSET_BITS-1:0] offset);
      logic [31:0] wide;
      wide = 32'(offset);
      return wide[15:0];
   endfunction

endpackage

`default_nettype wire

### design/tlt_if.sv
// ----------------------------------------------------------------------------
// Tokenizer channel interfaces
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface tlt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [7:0]  odd_byte;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start, output token_length,
                   output odd_byte, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_length,
                 input odd_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### design/tlt_scan.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Holds the scan state and turns one byte into up to two tokens per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toy_language_tokenizer_top_assert.svh"

module tlt_scan (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             char_byte,
   input  wire logic                   end_of_input,
   output      tlt_pkg::scan_out_type  scan_out
);

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_WORD = 3'd1;
   localparam logic [2:0] MODE_NUM  = 3'd2;
   localparam logic [2:0] MODE_OP   = 3'd3;

   logic [2:0]                       mode_ff, mode_in;
   logic [7:0]                       prefix_ff [tlt_pkg::KEYWORD_CHARS];
   logic [7:0]                       prefix_in [tlt_pkg::KEYWORD_CHARS];
   logic [15:0]                      run_length_ff, run_length_in;
   logic [tlt_pkg::OFFSET_BITS-1:0]  run_start_ff, run_start_in;
   logic [tlt_pkg::OFFSET_BITS-1:0]  byte_offset_ff, byte_offset_in;
   logic [7:0]                       held_ff, held_in;

   logic                 ending, is_space, is_alpha, is_digit, is_opc;
   logic                 single_hit, kw_same;
   logic [4:0]           single_kind, word_kind, pair_kind;
   logic                 flush_valid, extra_valid, do_flush;
   tlt_pkg::token_type   flush_tok, extra_tok;
   logic [15:0]          grown;

   always_comb begin
      ending   = end_of_input || (char_byte == tlt_pkg::CHAR_NUL);
      is_space = (char_byte == 8'd32) || (char_byte >= 8'd9 && char_byte <= 8'd13);
      is_alpha = (char_byte >= 8'd65 && char_byte <= 8'd90) ||
                 (char_byte >= 8'd97 && char_byte <= 8'd122);
      is_digit = char_byte >= 8'd48 && char_byte <= 8'd57;
      is_opc   = (char_byte == tlt_pkg::CHAR_EQ) || (char_byte == tlt_pkg::CHAR_BANG) ||
                 (char_byte == tlt_pkg::CHAR_GT) || (char_byte == tlt_pkg::CHAR_LT);
      grown    = (run_length_ff == tlt_pkg::LEN_MAX) ? run_length_ff : run_length_ff + 16'd1;

      single_hit  = 1'b0;
      single_kind = tlt_pkg::KIND_UNKNOWN;
      for (int i = 0; i < tlt_pkg::SINGLE_COUNT; i++) begin
         if (char_byte == tlt_pkg::SINGLE_CHARS[i]) begin
            single_hit  = 1'b1;
            single_kind = tlt_pkg::KIND_SINGLE0 + 5'(i);
         end
      end

      // The last keyword checked is the first in the list, so it wins a tie.
      word_kind = tlt_pkg::KIND_IDENT;
      for (int k = tlt_pkg::KW_COUNT - 1; k >= 0; k--) begin
         kw_same = run_length_ff == 16'(tlt_pkg::KW_LEN[k]);
         for (int i = 0; i < tlt_pkg::KW_MAX_LEN; i++) begin
            if ((3'(i) < tlt_pkg::KW_LEN[k]) && (prefix_ff[i] != tlt_pkg::KW_TEXT[k][i])) begin
               kw_same = 1'b0;
            end
         end
         if (kw_same) begin
            word_kind = tlt_pkg::KIND_KW0 + 5'(k);
         end
      end

      priority if (held_ff == tlt_pkg::CHAR_EQ) begin
         pair_kind = tlt_pkg::KIND_EQ;
      end else if (held_ff == tlt_pkg::CHAR_BANG) begin
         pair_kind = tlt_pkg::KIND_NE;
      end else if (held_ff == tlt_pkg::CHAR_GT) begin
         pair_kind = tlt_pkg::KIND_GE;
      end else begin
         pair_kind = tlt_pkg::KIND_LE;
      end

      flush_valid     = mode_ff != MODE_IDLE;
      flush_tok.start = tlt_pkg::start_field(run_start_ff);
      flush_tok.last  = 1'b0;
      flush_tok.odd   = 8'd0;
      flush_tok.length = 16'd1;
      flush_tok.kind  = tlt_pkg::KIND_UNKNOWN;
      unique case (mode_ff)
         MODE_WORD: begin
            flush_tok.kind   = word_kind;
            flush_tok.length = run_length_ff;
         end
         MODE_NUM: begin
            flush_tok.kind   = tlt_pkg::KIND_NUMBER;
            flush_tok.length = run_length_ff;
         end
         MODE_OP: begin
            priority if (held_ff == tlt_pkg::CHAR_EQ) begin
               flush_tok.kind = tlt_pkg::KIND_ASSIGN;
            end else if (held_ff == tlt_pkg::CHAR_GT) begin
               flush_tok.kind = tlt_pkg::KIND_GT;
            end else if (held_ff == tlt_pkg::CHAR_LT) begin
               flush_tok.kind = tlt_pkg::KIND_LT;
            end else begin
               flush_tok.odd = held_ff;
            end
         end
         default: begin
            flush_valid = 1'b0;
         end
      endcase

      mode_in        = mode_ff;
      prefix_in      = prefix_ff;
      run_length_in  = run_length_ff;
      run_start_in   = run_start_ff;
      held_in        = held_ff;
      byte_offset_in = byte_offset_ff;
      do_flush       = 1'b0;
      extra_valid    = 1'b0;
      extra_tok.kind   = tlt_pkg::KIND_UNKNOWN;
      extra_tok.start  = tlt_pkg::start_field(byte_offset_ff);
      extra_tok.length = 16'd1;
      extra_tok.odd    = 8'd0;
      extra_tok.last   = 1'b0;

      if (ending) begin
         do_flush         = 1'b1;
         extra_valid      = 1'b1;
         extra_tok.kind   = tlt_pkg::KIND_END;
         extra_tok.length = 16'd0;
         mode_in          = MODE_IDLE;
         run_length_in    = 16'd0;
         run_start_in     = '0;
         held_in          = 8'd0;
         byte_offset_in   = '0;
         for (int i = 0; i < tlt_pkg::KEYWORD_CHARS; i++) begin
            prefix_in[i] = 8'd0;
         end
      end else begin
         byte_offset_in = byte_offset_ff + tlt_pkg::OFFSET_BITS'(1);
         if (mode_ff == MODE_WORD && (is_alpha || is_digit)) begin
            for (int i = 0; i < tlt_pkg::KEYWORD_CHARS; i++) begin
               if (run_length_ff == 16'(i)) begin
                  prefix_in[i] = char_byte;
               end
            end
            run_length_in = grown;
         end else if (mode_ff == MODE_NUM && is_digit) begin
            run_length_in = grown;
         end else if (mode_ff == MODE_OP && char_byte == tlt_pkg::CHAR_EQ) begin
            extra_valid      = 1'b1;
            extra_tok.kind   = pair_kind;
            extra_tok.start  = tlt_pkg::start_field(run_start_ff);
            extra_tok.length = 16'd2;
            mode_in          = MODE_IDLE;
            held_in          = 8'd0;
         end else begin
            do_flush = 1'b1;
            mode_in  = MODE_IDLE;
            held_in  = 8'd0;
            if (!is_space) begin
               run_start_in  = byte_offset_ff;
               run_length_in = 16'd1;
               if (is_alpha) begin
                  for (int i = 0; i < tlt_pkg::KEYWORD_CHARS; i++) begin
                     prefix_in[i] = 8'd0;
                  end
                  prefix_in[0] = char_byte;
                  mode_in      = MODE_WORD;
               end else if (is_digit) begin
                  mode_in = MODE_NUM;
               end else if (is_opc) begin
                  held_in = char_byte;
                  mode_in = MODE_OP;
               end else begin
                  extra_valid    = 1'b1;
                  extra_tok.kind = single_kind;
                  extra_tok.odd  = single_hit ? 8'd0 : char_byte;
               end
            end
         end
      end

      scan_out.first  = extra_tok;
      scan_out.second = extra_tok;
      scan_out.count  = 2'd0;
      if (do_flush && flush_valid) begin
         scan_out.first = flush_tok;
         if (extra_valid) begin
            scan_out.second.last = 1'b1;
            scan_out.count       = 2'd2;
         end else begin
            scan_out.first.last = 1'b1;
            scan_out.count      = 2'd1;
         end
      end else if (extra_valid) begin
         scan_out.first.last = 1'b1;
         scan_out.count      = 2'd1;
      end
      if (!step) begin
         scan_out.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         run_length_ff  <= 16'd0;
         run_start_ff   <= '0;
         byte_offset_ff <= '0;
         held_ff        <= 8'd0;
         for (int i = 0; i < tlt_pkg::KEYWORD_CHARS; i++) begin
            prefix_ff[i] <= 8'd0;
         end
      end else if (step) begin
         mode_ff        <= mode_in;
         run_length_ff  <= run_length_in;
         run_start_ff   <= run_start_in;
         byte_offset_ff <= byte_offset_in;
         held_ff        <= held_in;
         prefix_ff      <= prefix_in;
      end
   end

   `TLT_ASSERT_NEXT(a_end_restarts, clock, reset, step && ending,
      mode_ff == MODE_IDLE && byte_offset_ff == '0 && run_length_ff == 16'd0)
   `TLT_ASSERT_IMPLY(a_end_yields_token, clock, reset, step && ending,
      scan_out.count != 2'd0)
   `TLT_ASSERT_IMPLY(a_pair_marks_second, clock, reset, scan_out.count == 2'd2,
      !scan_out.first.last && scan_out.second.last)
   `TLT_ASSERT_IMPLY(a_op_holds_char, clock, reset, mode_ff == MODE_OP,
      held_ff == tlt_pkg::CHAR_EQ || held_ff == tlt_pkg::CHAR_BANG ||
      held_ff == tlt_pkg::CHAR_GT || held_ff == tlt_pkg::CHAR_LT)

endmodule

`default_nettype wire

### design/toy_language_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Toy language tokenizer
// Streams source bytes into tokens of kind, start offset and length.
// ----------------------------------------------------------------------------
// The tokenizer takes one source byte per cycle while the queue has room, and
// gives its tokens after the byte is registered: the byte waits in the input
// register, then the scanner writes the tokens into a four-entry result queue
// that drives the output channel. A byte that closes one token and is itself a
// token (or an end of input that flushes a pending token) gives two tokens; the
// queue hands out one token a cycle while the receiver is ready, so a stream of
// such bytes is held back by the queue, while any other stream keeps one byte per
// cycle. The scanner takes the byte from the input register only while the queue has room for two tokens.
`default_nettype none

`include "toy_language_tokenizer_top_assert.svh"

module toy_language_tokenizer_top (
   input wire logic   clock,
   input wire logic   reset,
   tlt_req_if.sink    req_ch,
   tlt_rsp_if.source  rsp_ch
);

   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    in_byte_ff;
   logic                          in_eoi_ff;
   logic                          scan_step, pop;
   logic [tlt_pkg::QCNT_BITS-1:0] count_ff, count_in, count_after_pop;
   logic [tlt_pkg::QPTR_BITS-1:0] head_ff, tail_ff;
   tlt_pkg::token_type            queue_ff [tlt_pkg::QUEUE_DEPTH];
   tlt_pkg::scan_out_type         scan_out;

   tlt_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (scan_step),
      .char_byte    (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .scan_out     (scan_out)
   );

   always_comb begin
      pop             = rsp_ch.valid && rsp_ch.ready;
      count_after_pop = count_ff - tlt_pkg::QCNT_BITS'(pop);
      scan_step       = in_valid_ff &&
                        (count_after_pop <= tlt_pkg::QCNT_BITS'(tlt_pkg::QUEUE_DEPTH - 2));
      req_ch.ready    = !in_valid_ff || scan_step;
      in_valid_in     = req_ch.valid || (in_valid_ff && !scan_step);
      count_in        = count_after_pop + tlt_pkg::QCNT_BITS'(scan_out.count);
   end

   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.token_kind   = queue_ff[head_ff].kind;
   assign rsp_ch.token_start  = queue_ff[head_ff].start;
   assign rsp_ch.token_length = queue_ff[head_ff].length;
   assign rsp_ch.odd_byte     = queue_ff[head_ff].odd;
   assign rsp_ch.last_of_run  = queue_ff[head_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (pop) begin
            head_ff <= head_ff + tlt_pkg::QPTR_BITS'(1);
         end
         tail_ff <= tail_ff + tlt_pkg::QPTR_BITS'(scan_out.count);
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.char_byte;
         in_eoi_ff  <= req_ch.end_of_input;
      end
      if (scan_out.count != 2'd0) begin
         queue_ff[tail_ff] <= scan_out.first;
      end
      if (scan_out.count == 2'd2) begin
         queue_ff[tail_ff + tlt_pkg::QPTR_BITS'(1)] <= scan_out.second;
      end
   end

   `TLT_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= tlt_pkg::QCNT_BITS'(tlt_pkg::QUEUE_DEPTH))
   `TLT_ASSERT_ALWAYS(a_ptr_match, clock, reset,
      (tail_ff - head_ff) == count_ff[tlt_pkg::QPTR_BITS-1:0])
   `TLT_ASSERT_IMPLY(a_step_has_room, clock, reset, scan_step,
      count_in <= tlt_pkg::QCNT_BITS'(tlt_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the toy language tokenizer
// Drives source bytes through the request channel and compares every token on
// the result channel with the directed table or with a scanner kept in step
// inside the bench. A short table of directed bytes comes first, followed by
// random token streams under three idling mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 517;
   localparam int MAX_REPORTS    = 100;

   localparam logic [4:0] KIND_LPAREN = tlt_pkg::KIND_SINGLE0 + 5'd2;
   localparam logic [4:0] KIND_RETURN = tlt_pkg::KIND_KW0 + 5'd7;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] PAIR_CHARS [4] = '{
      tlt_pkg::CHAR_EQ, tlt_pkg::CHAR_BANG, tlt_pkg::CHAR_GT, tlt_pkg::CHAR_LT
   };

   localparam logic [1:0] SCAN_IDLE     = 2'd0;
   localparam logic [1:0] SCAN_WORD     = 2'd1;
   localparam logic [1:0] SCAN_NUMBER   = 2'd2;
   localparam logic [1:0] SCAN_OPERATOR = 2'd3;

   typedef struct packed {
      logic [7:0]  ch;
      logic        eoi;
      logic        typed;
      logic        has_token;
      logic [4:0]  want_kind;
      logic [15:0] want_start;
      logic [15:0] want_len;
      logic [7:0]  want_odd;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } source_item_type;

   // Typed rows are those whose tokens follow directly from the source text.
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{"(",   1'b0, 1'b1, 1'b1, KIND_LPAREN,           16'd0,  16'd1, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 1'b1, tlt_pkg::KIND_UNKNOWN, 16'd1,  16'd1, 8'hFF},
      '{8'h80, 1'b0, 1'b1, 1'b1, tlt_pkg::KIND_UNKNOWN, 16'd2,  16'd1, 8'h80},
      '{" ",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{8'h09, 1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{8'h0D, 1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"r",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"e",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"t",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"u",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"r",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"n",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{">",   1'b0, 1'b1, 1'b1, KIND_RETURN,           16'd6,  16'd6, 8'h00},
      '{"=",   1'b0, 1'b1, 1'b1, tlt_pkg::KIND_GE,      16'd12, 16'd2, 8'h00},
      '{"<",   1'b0, 1'b1, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"7",   1'b0, 1'b1, 1'b1, tlt_pkg::KIND_LT,      16'd14, 16'd1, 8'h00},
      '{"!",   1'b0, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"=",   1'b0, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"=",   1'b0, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"a",   1'b0, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{"q",   1'b1, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{8'hFF, 1'b1, 1'b1, 1'b1, tlt_pkg::KIND_END,     16'd0,  16'd0, 8'h00},
      '{8'h00, 1'b0, 1'b1, 1'b1, tlt_pkg::KIND_END,     16'd0,  16'd0, 8'h00},
      '{"!",   1'b0, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 1'b0, tlt_pkg::KIND_IDENT,   16'd0,  16'd0, 8'h00}
   };

   logic clock;
   logic reset;

   tlt_req_if req_ch ();
   tlt_rsp_if rsp_ch ();

   toy_language_tokenizer_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [1:0]  scan_mode;
   logic [7:0]  word_head [tlt_pkg::KEYWORD_CHARS];
   logic [15:0] run_len;
   logic [15:0] run_first;
   logic [15:0] src_offset;
   logic [7:0]  held_op;

   tlt_pkg::token_type step_tokens [$];
   tlt_pkg::token_type expected_tokens [$];
   source_item_type    source_items [$];

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned error_count;
   int unsigned stall_count;
   int unsigned hold_left;
   bit          hold_request;
   bit          hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_blank(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic bit is_numeral(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic tlt_pkg::token_type make_token(input logic [4:0] kind,
                                                     input logic [15:0] first,
                                                     input logic [15:0] len,
                                                     input logic [7:0] odd);
      tlt_pkg::token_type t;
      t.kind   = kind;
      t.start  = first;
      t.length = len;
      t.odd    = odd;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic void add_step_token(input tlt_pkg::token_type t);
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic void add_item(input logic [7:0] ch, input logic eoi);
      source_item_type entry;
      entry.ch  = ch;
      entry.eoi = eoi;
      source_items.insert(source_items.size(), entry);
   endfunction

   function automatic void clear_scanner();
      scan_mode  = SCAN_IDLE;
      run_len    = '0;
      run_first  = '0;
      src_offset = '0;
      held_op    = '0;
      foreach (word_head[i]) word_head[i] = '0;
   endfunction

   function automatic logic [4:0] word_kind();
      logic [4:0] kind;
      bit         same;
      kind = tlt_pkg::KIND_IDENT;
      for (int k = 0; k < tlt_pkg::KW_COUNT; k++) begin
         if (run_len == 16'(tlt_pkg::KW_LEN[k])) begin
            same = 1'b1;
            for (int i = 0; i < int'(tlt_pkg::KW_LEN[k]); i++) begin
               if (word_head[i] != tlt_pkg::KW_TEXT[k][i]) same = 1'b0;
            end
            if (same) kind = tlt_pkg::KIND_KW0 + 5'(k);
         end
      end
      return kind;
   endfunction

   function automatic void close_token();
      case (scan_mode)
         SCAN_WORD: begin
            add_step_token(make_token(word_kind(), run_first, run_len, 8'h00));
         end
         SCAN_NUMBER: begin
            add_step_token(make_token(tlt_pkg::KIND_NUMBER, run_first, run_len, 8'h00));
         end
         SCAN_OPERATOR: begin
            case (held_op)
               tlt_pkg::CHAR_EQ: begin
                  add_step_token(make_token(tlt_pkg::KIND_ASSIGN, run_first, 16'd1, 8'h00));
               end
               tlt_pkg::CHAR_GT: begin
                  add_step_token(make_token(tlt_pkg::KIND_GT, run_first, 16'd1, 8'h00));
               end
               tlt_pkg::CHAR_LT: begin
                  add_step_token(make_token(tlt_pkg::KIND_LT, run_first, 16'd1, 8'h00));
               end
               default: begin
                  add_step_token(make_token(tlt_pkg::KIND_UNKNOWN, run_first, 16'd1,
                                            held_op));
               end
            endcase
         end
         default: ;
      endcase
      scan_mode = SCAN_IDLE;
      held_op   = '0;
   endfunction

   function automatic void open_token(input logic [7:0] b);
      bit found;
      found = 1'b0;
      if (!is_blank(b)) begin
         run_first = src_offset;
         run_len   = 16'd1;
         if (is_letter(b)) begin
            foreach (word_head[i]) word_head[i] = '0;
            word_head[0] = b;
            scan_mode    = SCAN_WORD;
         end else if (is_numeral(b)) begin
            scan_mode = SCAN_NUMBER;
         end else if (b == tlt_pkg::CHAR_EQ || b == tlt_pkg::CHAR_BANG ||
                      b == tlt_pkg::CHAR_GT || b == tlt_pkg::CHAR_LT) begin
            held_op   = b;
            scan_mode = SCAN_OPERATOR;
         end else begin
            for (int i = 0; i < tlt_pkg::SINGLE_COUNT; i++) begin
               if (!found && b == tlt_pkg::SINGLE_CHARS[i]) begin
                  add_step_token(make_token(tlt_pkg::KIND_SINGLE0 + 5'(i), src_offset,
                                            16'd1, 8'h00));
                  found = 1'b1;
               end
            end
            if (!found) begin
               add_step_token(make_token(tlt_pkg::KIND_UNKNOWN, src_offset, 16'd1, b));
            end
         end
      end
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic eoi);
      tlt_pkg::token_type tail;
      logic [4:0]         pair_kind;
      step_tokens.delete();
      if (eoi || b == tlt_pkg::CHAR_NUL) begin
         close_token();
         add_step_token(make_token(tlt_pkg::KIND_END, src_offset, 16'd0, 8'h00));
         clear_scanner();
      end else begin
         case (scan_mode)
            SCAN_WORD: begin
               if (is_letter(b) || is_numeral(b)) begin
                  if (run_len < tlt_pkg::KEYWORD_CHARS) word_head[run_len] = b;
                  if (run_len != tlt_pkg::LEN_MAX) run_len = run_len + 16'd1;
               end else begin
                  close_token();
                  open_token(b);
               end
            end
            SCAN_NUMBER: begin
               if (is_numeral(b)) begin
                  if (run_len != tlt_pkg::LEN_MAX) run_len = run_len + 16'd1;
               end else begin
                  close_token();
                  open_token(b);
               end
            end
            SCAN_OPERATOR: begin
               if (b == tlt_pkg::CHAR_EQ) begin
                  pair_kind = (held_op == tlt_pkg::CHAR_EQ)   ? tlt_pkg::KIND_EQ :
                              (held_op == tlt_pkg::CHAR_BANG) ? tlt_pkg::KIND_NE :
                              (held_op == tlt_pkg::CHAR_GT)   ? tlt_pkg::KIND_GE :
                                                                tlt_pkg::KIND_LE;
                  add_step_token(make_token(pair_kind, run_first, 16'd2, 8'h00));
                  scan_mode = SCAN_IDLE;
                  held_op   = '0;
               end else begin
                  close_token();
                  open_token(b);
               end
            end
            default: open_token(b);
         endcase
         src_offset = src_offset + 16'd1;
      end
      if (step_tokens.size() > 0) begin
         tail      = step_tokens.pop_back();
         tail.last = 1'b1;
         add_step_token(tail);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s got %0d expected %0d", $time, what, got, want);
      end
   endtask

   task automatic check_token();
      tlt_pkg::token_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("token with none pending, kind", 16'(rsp_ch.token_kind), 16'd0);
      end else begin
         want = expected_tokens.pop_front();
         if (rsp_ch.token_kind !== want.kind)
            report_mismatch("token_kind", 16'(rsp_ch.token_kind), 16'(want.kind));
         if (rsp_ch.token_start !== want.start)
            report_mismatch("token_start", rsp_ch.token_start, want.start);
         if (rsp_ch.token_length !== want.length)
            report_mismatch("token_length", rsp_ch.token_length, want.length);
         if (rsp_ch.odd_byte !== want.odd)
            report_mismatch("odd_byte", 16'(rsp_ch.odd_byte), 16'(want.odd));
         if (rsp_ch.last_of_run !== want.last)
            report_mismatch("last_of_run", 16'(rsp_ch.last_of_run), 16'(want.last));
      end
   endtask

   task automatic send_item(input logic [7:0] b, input logic eoi, input bit typed,
                            input bit typed_has, input tlt_pkg::token_type typed_tok);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.char_byte    <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      scan_byte(b, eoi);
      if (typed) begin
         if (typed_has) expected_tokens.insert(expected_tokens.size(), typed_tok);
      end else begin
         foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
      end
   endtask

   function automatic logic [7:0] pick_letter();
      return $urandom_range(3) != 0 ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
   endfunction

   function automatic logic [7:0] pick_numeral();
      return 8'($urandom_range(48, 57));
   endfunction

   function automatic void compose_token();
      int unsigned pick;
      int unsigned k;
      int unsigned n;
      logic [7:0]  c;
      pick = $urandom_range(99);
      if (pick < 43 && $urandom_range(9) < 7) add_item(CHAR_SPACE, 1'b0);
      if (pick < 15) begin
         k = $urandom_range(tlt_pkg::KW_COUNT - 1);
         for (int i = 0; i < int'(tlt_pkg::KW_LEN[k]); i++) add_item(tlt_pkg::KW_TEXT[k][i], 1'b0);
         if ($urandom_range(3) == 0) add_item(pick_letter(), 1'b0);
      end else if (pick < 30) begin
         add_item(pick_letter(), 1'b0);
         n = $urandom_range(8);
         for (int i = 0; i < int'(n); i++) begin
            c = $urandom_range(2) == 0 ? pick_numeral() : pick_letter();
            add_item(c, 1'b0);
         end
      end else if (pick < 43) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < int'(n); i++) add_item(pick_numeral(), 1'b0);
      end else if (pick < 56) begin
         add_item(PAIR_CHARS[$urandom_range(3)], 1'b0);
         if ($urandom_range(1) == 1) add_item(tlt_pkg::CHAR_EQ, 1'b0);
      end else if (pick < 71) begin
         add_item(tlt_pkg::SINGLE_CHARS[$urandom_range(tlt_pkg::SINGLE_COUNT - 1)], 1'b0);
      end else if (pick < 85) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < int'(n); i++) begin
            c = 8'($urandom_range(8, 13));
            add_item((c == 8'd8) ? CHAR_SPACE : c, 1'b0);
         end
      end else if (pick < 95) begin
         add_item(8'($urandom_range(1, 255)), 1'b0);
      end else if ($urandom_range(1) == 1) begin
         add_item(8'($urandom_range(255)), 1'b1);
      end else begin
         add_item(tlt_pkg::CHAR_NUL, 1'b0);
      end
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned     sent;
      source_item_type item;
      sent = 0;
      while (sent < count) begin
         compose_token();
         while (source_items.size() > 0) begin
            item = source_items.pop_front();
            send_item(item.ch, item.eoi, 1'b0, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_token();
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_count <= 0;
      end else if (stall_count + 1 >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      directed_row_type   row;
      tlt_pkg::token_type typed_tok;
      req_ch.valid        <= 1'b0;
      req_ch.char_byte    <= 8'h00;
      req_ch.end_of_input <= 1'b0;
      reset               <= 1'b1;
      error_count       = 0;
      stall_count       = 0;
      hold_left         = 0;
      hold_request      = 1'b0;
      hold_done         = 1'b0;
      sender_idle_pct   = 12;
      receiver_idle_pct = 47;
      clear_scanner();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row       = DIRECTED_ROWS[i];
         typed_tok = make_token(row.want_kind, row.want_start, row.want_len, row.want_odd);
         typed_tok.last = 1'b1;
         send_item(row.ch, row.eoi, row.typed, row.has_token, typed_tok);
      end

      run_random(PHASE_ITEMS);
      sender_idle_pct   = 47;
      receiver_idle_pct = 12;
      run_random(PHASE_ITEMS);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_request      = 1'b1;
      run_random(PHASE_ITEMS);

      req_ch.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
